@@ design/bada_pkg.sv @@
// ----------------------------------------------------------------------------
// bada_pkg: shared types and constants for the block average alarm
// Field widths, register indexes, reset values and item kind codes.
// ----------------------------------------------------------------------------
package bada_pkg;

  localparam int SAMPLE_W  = 12;
  localparam int CNT_W     = 16;
  localparam int CFG_W     = 16;
  localparam int CFG_IDX_W = 2;
  localparam int DATA_W    = 16;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RISE_LIMIT  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FALL_RELOAD = 2'd2;

  localparam logic [SAMPLE_W-1:0] THRESHOLD_RESET   = 12'd500;
  localparam logic [CNT_W-1:0]    RISE_LIMIT_RESET  = 16'd40;
  localparam logic [CNT_W-1:0]    FALL_RELOAD_RESET = 16'd20;

  // item kinds carried in tuser
  localparam logic MODE_SAMPLE = 1'b0;
  localparam logic MODE_TICK   = 1'b1;

  typedef struct packed {
    logic [SAMPLE_W-1:0] threshold;
    logic [CNT_W-1:0]    rise_limit;
    logic [CNT_W-1:0]    fall_reload;
  } cfg_t;

endpackage

@@ design/bada_window.sv @@
// ----------------------------------------------------------------------------
// bada_window: windowed sample accumulator and mean
// Sums the kept samples of each window and forms the mean at the window end
// with a reciprocal multiply.
// ----------------------------------------------------------------------------
module bada_window #(
  parameter int WINDOW = 32,
  parameter int SKIP   = 1
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          en,
  input  logic [bada_pkg::SAMPLE_W-1:0] sample,
  output logic [bada_pkg::SAMPLE_W-1:0] mean,
  output logic [bada_pkg::SAMPLE_W-1:0] mean_next,
  output logic                          done_next
);

  localparam int IDX_W  = $clog2(WINDOW);
  localparam int SUM_W  = $clog2(WINDOW * ((1 << bada_pkg::SAMPLE_W) - 1) + 1);
  localparam int DIV    = WINDOW - SKIP;
  localparam int DIV_L  = $clog2(DIV);
  localparam int SH     = SUM_W + DIV_L;
  localparam int MULT_W = SUM_W + 1;
  localparam int PROD_W = SUM_W + MULT_W;
  // ceil(2^SH / DIV) gives the exact quotient for any SUM_W-bit sum
  localparam longint unsigned MULT = ((64'd1 << SH) + longint'(DIV) - 64'd1) / longint'(DIV);
  localparam logic [MULT_W-1:0] MULT_C = MULT_W'(MULT);
  localparam logic [IDX_W-1:0]  LAST_IDX = IDX_W'(WINDOW - 1);
  localparam logic [IDX_W-1:0]  SKIP_IDX = IDX_W'(SKIP);

  logic [IDX_W-1:0]  sample_index;
  logic [SUM_W-1:0]  sample_sum;
  logic [SUM_W-1:0]  sum_add;
  logic [PROD_W-1:0] product;
  logic              last;

  assign last    = (sample_index == LAST_IDX);
  assign sum_add = (sample_index >= SKIP_IDX) ? sample_sum + SUM_W'(sample) : sample_sum;
  assign product = PROD_W'(sum_add) * PROD_W'(MULT_C);

  assign done_next = en && last;
  assign mean_next = done_next ? product[SH +: bada_pkg::SAMPLE_W] : mean;

  always_ff @(posedge clk) begin
    if (rst) begin
      sample_index <= '0;
      sample_sum   <= '0;
      mean         <= '0;
    end else if (en) begin
      if (last) begin
        sample_index <= '0;
        sample_sum   <= '0;
        mean         <= mean_next;
      end else begin
        sample_index <= sample_index + 1'b1;
        sample_sum   <= sum_add;
      end
    end
  end

`ifndef SYNTHESIS
  a_sum_clear_at_start: assert property (@(posedge clk) disable iff (rst)
    (sample_index == '0) |-> (sample_sum == '0))
    else $error("window sum not clear at window start");

  a_mean_only_at_end: assert property (@(posedge clk) disable iff (rst)
    !done_next |=> $stable(mean))
    else $error("mean changed outside a window end");
`endif

endmodule

@@ design/bada_debounce.sv @@
// ----------------------------------------------------------------------------
// bada_debounce: debounced low-level alarm
// Rise and fall counters driven by evaluation ticks set and clear the alarm.
// ----------------------------------------------------------------------------
module bada_debounce (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          en,
  input  logic [bada_pkg::SAMPLE_W-1:0] mean,
  input  bada_pkg::cfg_t                cfg,
  output logic                          alarm_next
);

  logic [bada_pkg::CNT_W-1:0] rise_count;
  logic [bada_pkg::CNT_W-1:0] rise_count_next;
  logic [bada_pkg::CNT_W-1:0] fall_count;
  logic [bada_pkg::CNT_W-1:0] fall_count_next;
  logic                       alarm;

  always_comb begin
    rise_count_next = rise_count;
    fall_count_next = fall_count;
    alarm_next      = alarm;
    if (en) begin
      if (mean < cfg.threshold) begin
        if (rise_count < cfg.rise_limit) begin
          rise_count_next = rise_count + 1'b1;
        end else begin
          rise_count_next = '0;
          fall_count_next = cfg.fall_reload;
          alarm_next      = 1'b1;
        end
      end else begin
        if (fall_count != '0) begin
          fall_count_next = fall_count - 1'b1;
        end else begin
          fall_count_next = cfg.fall_reload;
          rise_count_next = '0;
          alarm_next      = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rise_count <= '0;
      fall_count <= bada_pkg::FALL_RELOAD_RESET;
      alarm      <= 1'b0;
    end else begin
      rise_count <= rise_count_next;
      fall_count <= fall_count_next;
      alarm      <= alarm_next;
    end
  end

`ifndef SYNTHESIS
  a_rise_reloads: assert property (@(posedge clk) disable iff (rst)
    $rose(alarm) |-> (rise_count == '0) && (fall_count == $past(cfg.fall_reload)))
    else $error("alarm set without counter reload");

  a_fall_clears_rise: assert property (@(posedge clk) disable iff (rst)
    $fell(alarm) |-> (rise_count == '0))
    else $error("alarm cleared without clearing rise count");
`endif

endmodule

@@ design/block_average_debounced_low_alarm_unit.sv @@
// ----------------------------------------------------------------------------
// block_average_debounced_low_alarm_unit: block average with low alarm
// Averages ADC samples over fixed windows and raises a debounced alarm when
// the mean stays below a threshold on evaluation ticks.
//
//   channel   direction  payload
//   s_axis    in         tdata: sample; tuser: mode
//   m_axis    out        tdata: average; tuser: alarm, window_done
//   cfg       in         cfg_index selects threshold, rise_limit, fall_reload
//
// One transaction per cycle in each direction while m_axis does not stall; every input
// gives one result, held first in the input register and then in the result register.
// The window end path is one add and one reciprocal multiply.
// rst is synchronous; the result register keeps its data while m_axis stalls,
// and an input waits in the input register until the result register frees.
// ----------------------------------------------------------------------------
module block_average_debounced_low_alarm_unit #(
  parameter int WINDOW = 32,
  parameter int SKIP   = 1
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [bada_pkg::DATA_W-1:0]    s_axis_tdata,  // [11:0] sample
  input  logic                           s_axis_tuser,  // [0] mode
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  output logic [bada_pkg::DATA_W-1:0]    m_axis_tdata,  // [11:0] average
  output logic [1:0]                     m_axis_tuser,  // [0] alarm, [1] window_done
  input  logic                           cfg_we,
  input  logic [bada_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [bada_pkg::CFG_W-1:0]     cfg_data
);

  bada_pkg::cfg_t cfg;

  logic                          in_valid;
  logic                          in_mode;
  logic [bada_pkg::SAMPLE_W-1:0] in_sample;
  logic                          proc;
  logic                          win_en;
  logic                          deb_en;
  logic [bada_pkg::SAMPLE_W-1:0] mean;
  logic [bada_pkg::SAMPLE_W-1:0] mean_next;
  logic                          done_next;
  logic                          alarm_next;
  logic [bada_pkg::SAMPLE_W-1:0] average;
  logic                          alarm;
  logic                          window_done;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.threshold   <= bada_pkg::THRESHOLD_RESET;
      cfg.rise_limit  <= bada_pkg::RISE_LIMIT_RESET;
      cfg.fall_reload <= bada_pkg::FALL_RELOAD_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        bada_pkg::REG_THRESHOLD:   cfg.threshold   <= cfg_data[bada_pkg::SAMPLE_W-1:0];
        bada_pkg::REG_RISE_LIMIT:  cfg.rise_limit  <= cfg_data;
        bada_pkg::REG_FALL_RELOAD: cfg.fall_reload <= cfg_data;
        default: ;
      endcase
    end
  end

  // advance the held item whenever the result register is free or draining
  assign proc          = in_valid && (!m_axis_tvalid || m_axis_tready);
  assign s_axis_tready = !in_valid || proc;
  assign win_en        = proc && (in_mode == bada_pkg::MODE_SAMPLE);
  assign deb_en        = proc && (in_mode == bada_pkg::MODE_TICK);

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_mode   <= s_axis_tuser;
      in_sample <= s_axis_tdata[bada_pkg::SAMPLE_W-1:0];
    end
  end

  bada_window #(
    .WINDOW (WINDOW),
    .SKIP   (SKIP)
  ) u_window (
    .clk       (clk),
    .rst       (rst),
    .en        (win_en),
    .sample    (in_sample),
    .mean      (mean),
    .mean_next (mean_next),
    .done_next (done_next)
  );

  bada_debounce u_debounce (
    .clk        (clk),
    .rst        (rst),
    .en         (deb_en),
    .mean       (mean),
    .cfg        (cfg),
    .alarm_next (alarm_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (proc) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (proc) begin
      average     <= mean_next;
      alarm       <= alarm_next;
      window_done <= done_next;
    end
  end

  assign m_axis_tdata = {{(bada_pkg::DATA_W - bada_pkg::SAMPLE_W){1'b0}}, average};
  assign m_axis_tuser = {window_done, alarm};

`ifndef SYNTHESIS
  a_stall_only_when_full: assert property (@(posedge clk) disable iff (rst)
    !s_axis_tready |-> (in_valid && m_axis_tvalid && !m_axis_tready))
    else $error("input stalled while the result register was free");

  a_done_from_sample: assert property (@(posedge clk) disable iff (rst)
    (proc && (in_mode == bada_pkg::MODE_TICK)) |=> !window_done)
    else $error("window done reported for an evaluation tick");
`endif

endmodule
